// File: design/tfn_pkg.sv
package tfn_pkg;

   // normalised cross-product component, leading one at bit 30
   localparam int MANT_W = 31;
   localparam int SQ_W   = 64;
   localparam int ROOT_W = 32;
   localparam int NORM_W = 16;
   localparam int PROD_W = MANT_W + ROOT_W;
   localparam int RND_SHIFT = 47;
   localparam logic [NORM_W:0] NORM_ONE = 17'd16384;

   // square root: 32 iterations, two per stage
   localparam int SQRT_STAGES = 16;
   localparam int SQRT_PER    = 2;
   // reciprocal: 32 quotient bits, two per stage
   localparam int RECIP_STAGES = 16;
   localparam int RECIP_PER    = 2;
   // 2^61 / 2^32: partial remainder before the first quotient bit
   localparam logic [ROOT_W-1:0] RECIP_START = 32'h2000_0000;

   typedef logic [MANT_W-1:0] mant_type;

   typedef struct packed {
      mant_type [2:0] m;
      logic [2:0]     neg;
      logic           degen;
   } side_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [ROOT_W-1:0] rem;
      logic [ROOT_W-1:0] quo;
   } div_type;

   // one restoring square-root iteration
   function automatic sqrt_type sqrt_step(input sqrt_type cur, input logic [SQ_W-1:0] bitv);
      sqrt_type        nxt;
      logic [SQ_W-1:0] trial;
      trial = cur.root + bitv;
      if (cur.rem >= trial) begin
         nxt.rem  = cur.rem - trial;
         nxt.root = (cur.root >> 1) + bitv;
      end else begin
         nxt.rem  = cur.rem;
         nxt.root = cur.root >> 1;
      end
      return nxt;
   endfunction

   // one restoring division step, numerator bits below the start are zero
   function automatic div_type div_step(input div_type cur, input logic [ROOT_W-1:0] den);
      div_type         nxt;
      logic [ROOT_W:0] trial;
      logic [ROOT_W:0] diff;
      trial = {cur.rem, 1'b0};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         nxt.rem = diff[ROOT_W-1:0];
         nxt.quo = {cur.quo[ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem = trial[ROOT_W-1:0];
         nxt.quo = {cur.quo[ROOT_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

// File: design/tfn_cross.sv
module tfn_cross
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [8:0][COORD_WIDTH-1:0]       in_corner,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [2:0][2*COORD_WIDTH+1:0]     out_mag,
   output logic [2:0]                        out_neg
);

   localparam int EW   = COORD_WIDTH + 1;
   localparam int PW   = 2 * COORD_WIDTH + 2;
   localparam int STG  = 3;

   logic [STG-1:0] v_ff, v_in, en;

   logic signed [EW-1:0]   u_ff [3], ve_ff [3];
   logic signed [PW-1:0]   p_ff [6];
   logic [PW-1:0]          mag_ff [3];
   logic [2:0]             neg_ff;

   logic signed [EW-1:0]   u_in [3], ve_in [3];
   logic signed [PW-1:0]   p_in [6];
   logic [PW-1:0]          mag_in [3];
   logic [2:0]             neg_in;
   logic signed [PW:0]     diff [3];

   // stall chain: a stage moves when it is empty or the next one moves
   always_comb begin
      en[STG-1] = !v_ff[STG-1] || out_ready;
      for (int i = STG - 2; i >= 0; i--) en[i] = !v_ff[i] || en[i+1];
      v_in[0] = in_valid;
      for (int i = 1; i < STG; i++) v_in[i] = v_ff[i-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STG; i++) if (en[i]) v_ff[i] <= v_in[i];
      end
   end

   // form the edges p1-p0 and p2-p0
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_in[i]  = $signed({in_corner[3+i][COORD_WIDTH-1], in_corner[3+i]})
                  - $signed({in_corner[i][COORD_WIDTH-1], in_corner[i]});
         ve_in[i] = $signed({in_corner[6+i][COORD_WIDTH-1], in_corner[6+i]})
                  - $signed({in_corner[i][COORD_WIDTH-1], in_corner[i]});
      end
   end

   // six partial products of the cross product
   always_comb begin
      p_in[0] = PW'(u_ff[1] * ve_ff[2]);
      p_in[1] = PW'(u_ff[2] * ve_ff[1]);
      p_in[2] = PW'(u_ff[2] * ve_ff[0]);
      p_in[3] = PW'(u_ff[0] * ve_ff[2]);
      p_in[4] = PW'(u_ff[0] * ve_ff[1]);
      p_in[5] = PW'(u_ff[1] * ve_ff[0]);
   end

   // subtract and split into sign and magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]   = (PW+1)'(p_ff[2*i]) - (PW+1)'(p_ff[2*i+1]);
         neg_in[i] = diff[i][PW];
         mag_in[i] = neg_in[i] ? PW'(-diff[i]) : PW'(diff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         u_ff  <= u_in;
         ve_ff <= ve_in;
      end
      if (en[1]) p_ff <= p_in;
      if (en[2]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[STG-1];
   assign out_neg   = neg_ff;
   always_comb for (int i = 0; i < 3; i++) out_mag[i] = mag_ff[i];

endmodule

// File: design/tfn_norm.sv
module tfn_norm
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [2:0][2*COORD_WIDTH+1:0] in_mag,
   input  logic [2:0]                    in_neg,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [SQ_W-1:0]               out_sq,
   output side_type                      out_side
);

   localparam int MAGW = 2 * COORD_WIDTH + 2;
   localparam int TW   = $clog2(MAGW);
   localparam int EXTW = MAGW + MANT_W - 1;
   localparam int STG  = 4;

   logic [STG-1:0] v_ff, v_in, en;

   logic [2:0][MAGW-1:0]        mag_ff;
   logic [2:0]                  neg_ff;
   logic [TW-1:0]               top_ff, top_in;
   logic                        zero_ff, zero_in;
   logic [MAGW-1:0]             orv;
   side_type                    side_b_ff, side_b_in, side_c_ff, side_d_ff;
   logic [2*MANT_W-1:0]         sq_ff [3];
   logic [SQ_W-1:0]             sum_ff, sum_in;
   logic [EXTW-1:0]             ext;

   always_comb begin
      en[STG-1] = !v_ff[STG-1] || out_ready;
      for (int i = STG - 2; i >= 0; i--) en[i] = !v_ff[i] || en[i+1];
      v_in[0] = in_valid;
      for (int i = 1; i < STG; i++) v_in[i] = v_ff[i-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STG; i++) if (en[i]) v_ff[i] <= v_in[i];
      end
   end

   // find the highest set bit over the three magnitudes
   always_comb begin
      orv     = in_mag[0] | in_mag[1] | in_mag[2];
      zero_in = (orv == '0);
      top_in  = '0;
      for (int b = 0; b < MAGW; b++) if (orv[b]) top_in = TW'(b);
   end

   // shift every magnitude by the same amount, leading one to bit 30
   always_comb begin
      ext = '0;
      for (int i = 0; i < 3; i++) begin
         ext = {mag_ff[i], {(MANT_W-1){1'b0}}} >> top_ff;
         side_b_in.m[i] = ext[MANT_W-1:0];
      end
      side_b_in.neg   = neg_ff;
      side_b_in.degen = zero_ff;
   end

   // sum of squares
   always_comb begin
      sum_in = SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mag_ff  <= in_mag;
         neg_ff  <= in_neg;
         top_ff  <= top_in;
         zero_ff <= zero_in;
      end
      if (en[1]) side_b_ff <= side_b_in;
      if (en[2]) begin
         for (int i = 0; i < 3; i++) sq_ff[i] <= side_b_ff.m[i] * side_b_ff.m[i];
         side_c_ff <= side_b_ff;
      end
      if (en[3]) begin
         sum_ff    <= sum_in;
         side_d_ff <= side_c_ff;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[STG-1];
   assign out_sq    = sum_ff;
   assign out_side  = side_d_ff;

endmodule

// File: design/tfn_isqrt.sv
module tfn_isqrt
   import tfn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [SQ_W-1:0]   in_sq,
   input  side_type          in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [ROOT_W-1:0] out_root,
   output side_type          out_side
);

   localparam int STG = SQRT_STAGES;

   logic [STG-1:0] v_ff, v_in, en;
   sqrt_type       acc_ff [STG];
   side_type       side_ff [STG];

   always_comb begin
      en[STG-1] = !v_ff[STG-1] || out_ready;
      for (int i = STG - 2; i >= 0; i--) en[i] = !v_ff[i] || en[i+1];
      v_in[0] = in_valid;
      for (int i = 1; i < STG; i++) v_in[i] = v_ff[i-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STG; i++) if (en[i]) v_ff[i] <= v_in[i];
      end
   end

   // two root bits per stage, trial bit walking down from bit 62
   for (genvar g = 0; g < STG; g++) begin : g_stage
      sqrt_type src;
      sqrt_type acc_in;
      side_type side_src;
      if (g == 0) begin : g_first
         assign src.rem  = in_sq;
         assign src.root = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign src      = acc_ff[g-1];
         assign side_src = side_ff[g-1];
      end
      always_comb begin
         acc_in = src;
         for (int j = 0; j < SQRT_PER; j++)
            acc_in = sqrt_step(acc_in,
                               SQ_W'(1) << (SQ_W - 2 - 2 * (g * SQRT_PER + j)));
      end
      always_ff @(posedge clock) begin
         if (en[g]) begin
            acc_ff[g]  <= acc_in;
            side_ff[g] <= side_src;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[STG-1];
   assign out_root  = acc_ff[STG-1].root[ROOT_W-1:0];
   assign out_side  = side_ff[STG-1];

endmodule

// File: design/tfn_recip.sv
module tfn_recip
   import tfn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [ROOT_W-1:0] in_root,
   input  side_type          in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [ROOT_W-1:0] out_recip,
   output side_type          out_side
);

   localparam int STG = RECIP_STAGES;

   logic [STG-1:0]    v_ff, v_in, en;
   div_type           acc_ff [STG];
   logic [ROOT_W-1:0] den_ff [STG];
   side_type          side_ff [STG];

   always_comb begin
      en[STG-1] = !v_ff[STG-1] || out_ready;
      for (int i = STG - 2; i >= 0; i--) en[i] = !v_ff[i] || en[i+1];
      v_in[0] = in_valid;
      for (int i = 1; i < STG; i++) v_in[i] = v_ff[i-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STG; i++) if (en[i]) v_ff[i] <= v_in[i];
      end
   end

   // two quotient bits per stage of 2^61 / root
   for (genvar g = 0; g < STG; g++) begin : g_stage
      div_type           src;
      div_type           acc_in;
      logic [ROOT_W-1:0] den_src;
      side_type          side_src;
      if (g == 0) begin : g_first
         assign src.rem  = RECIP_START;
         assign src.quo  = '0;
         assign den_src  = in_root;
         assign side_src = in_side;
      end else begin : g_next
         assign src      = acc_ff[g-1];
         assign den_src  = den_ff[g-1];
         assign side_src = side_ff[g-1];
      end
      always_comb begin
         acc_in = src;
         for (int j = 0; j < RECIP_PER; j++) acc_in = div_step(acc_in, den_src);
      end
      always_ff @(posedge clock) begin
         if (en[g]) begin
            acc_ff[g]  <= acc_in;
            den_ff[g]  <= den_src;
            side_ff[g] <= side_src;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[STG-1];
   assign out_recip = acc_ff[STG-1].quo;
   assign out_side  = side_ff[STG-1];

endmodule

// File: design/triangle_facet_normal_top.sv
// Channel  Direction  Handshake            Payload
// req      in         req_tvalid/tready    req_tdata: corners p0, p1, p2 (x, y, z)
// rsp      out        rsp_tvalid/tready    rsp_tdata: normal x, y, z; rsp_tuser: degenerate
//
// One request enters per cycle while the output does not stall; a result passes
// through 3 cross-product, 4 normalise, 16 square-root, 16 reciprocal and 2 scale stages.
// The square root and the reciprocal each resolve two bits per stage.
// Reset clears the valid bits of every stage; payload registers are not reset.
// A stalled output holds; earlier stages still close up bubbles behind it.
module triangle_facet_normal_top
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // corner0_x, corner0_y, corner0_z, corner1_x .. corner2_z, zero fill
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // normal_x, normal_y, normal_z
   output logic [3*NORM_W-1:0]                  rsp_tdata,
   // degenerate
   output logic                                 rsp_tuser
);

   localparam int MAGW = 2 * COORD_WIDTH + 2;
   localparam int STG  = 2;

   logic [8:0][COORD_WIDTH-1:0] corner;
   logic                        cr_valid, cr_ready, nm_valid, nm_ready;
   logic                        sq_valid, sq_ready, rc_valid, rc_ready;
   logic [2:0][MAGW-1:0]        cr_mag;
   logic [2:0]                  cr_neg;
   logic [SQ_W-1:0]             nm_sq;
   side_type                    nm_side, sq_side, rc_side, side_p_ff;
   logic [ROOT_W-1:0]           sq_root, rc_recip;
   logic [PROD_W-1:0]           prod_ff [3];
   logic [STG-1:0]              v_ff, v_in, en;
   logic [3*NORM_W-1:0]         data_ff, data_in;
   logic                        degen_ff;
   logic [SQ_W-1:0]             rnd;
   logic [NORM_W:0]             n;
   logic [NORM_W-1:0]           comp;

   always_comb for (int i = 0; i < 9; i++)
      corner[i] = req_tdata[i*COORD_WIDTH +: COORD_WIDTH];

   tfn_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_corner(corner),
      .out_valid(cr_valid), .out_ready(cr_ready), .out_mag(cr_mag), .out_neg(cr_neg)
   );

   tfn_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm (
      .clock(clock), .reset(reset),
      .in_valid(cr_valid), .in_ready(cr_ready), .in_mag(cr_mag), .in_neg(cr_neg),
      .out_valid(nm_valid), .out_ready(nm_ready), .out_sq(nm_sq), .out_side(nm_side)
   );

   tfn_isqrt u_isqrt (
      .clock(clock), .reset(reset),
      .in_valid(nm_valid), .in_ready(nm_ready), .in_sq(nm_sq), .in_side(nm_side),
      .out_valid(sq_valid), .out_ready(sq_ready), .out_root(sq_root), .out_side(sq_side)
   );

   tfn_recip u_recip (
      .clock(clock), .reset(reset),
      .in_valid(sq_valid), .in_ready(sq_ready), .in_root(sq_root), .in_side(sq_side),
      .out_valid(rc_valid), .out_ready(rc_ready), .out_recip(rc_recip),
      .out_side(rc_side)
   );

   // stall chain of the scale stages
   always_comb begin
      en[STG-1] = !v_ff[STG-1] || rsp_tready;
      en[0]     = !v_ff[0] || en[1];
      v_in[0]   = rc_valid;
      v_in[1]   = v_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STG; i++) if (en[i]) v_ff[i] <= v_in[i];
      end
   end

   // round, saturate at one, restore the sign and zero a degenerate normal
   always_comb begin
      data_in = '0;
      rnd     = '0;
      n       = '0;
      comp    = '0;
      for (int i = 0; i < 3; i++) begin
         rnd  = SQ_W'(prod_ff[i]) + (SQ_W'(1) << (RND_SHIFT - 1));
         n    = rnd[RND_SHIFT +: NORM_W+1];
         if (n > NORM_ONE) n = NORM_ONE;
         comp = side_p_ff.neg[i] ? NORM_W'(-n) : n[NORM_W-1:0];
         if (side_p_ff.degen) comp = '0;
         data_in[i*NORM_W +: NORM_W] = comp;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) prod_ff[i] <= rc_side.m[i] * rc_recip;
         side_p_ff <= rc_side;
      end
      if (en[1]) begin
         data_ff  <= data_in;
         degen_ff <= side_p_ff.degen;
      end
   end

   assign rc_ready   = en[0];
   assign rsp_tvalid = v_ff[STG-1];
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = degen_ff;

   // a degenerate result carries a zero normal
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate result with non-zero normal");

   // an empty output stage leaves the whole pipeline ready
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline not ready with empty output");

   // the x component stays within plus and minus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[0 +: NORM_W]) <= $signed(17'(NORM_ONE)))
                  && ($signed(rsp_tdata[0 +: NORM_W]) >= -$signed(17'(NORM_ONE))))
      else $error("normal x out of range");

endmodule
